// ===== sv/baro_pressure_temp_compensation_core_defines.svh =====
// Assertion macros for the barometric compensation core.
// Included by every RTL file that carries concurrent assertions; no other dependencies.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_CORE_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define BPTC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bptc assertion failed");

// Next-cycle implication, disabled while reset is high
`define BPTC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bptc assertion failed");

`endif

// ===== sv/bptc_pkg.sv =====
// Package for the barometric compensation core: widths, constants, register indexes
// and the structs passed between pipeline sections. No dependencies.
`timescale 1ns / 1ps

package bptc_pkg;

   // Field widths
   localparam int RAW_W       = 24;
   localparam int COEFF_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int TEMP_W      = 15;
   localparam int PRES_W      = 17;

   // Internal widths
   localparam int DT_W    = 25;                  // D2 - C5*2^8
   localparam int PROD_W  = DT_W + COEFF_W + 1;  // dT times a calibration word
   localparam int DSQ_W   = 2 * DT_W - 2;        // dT squared, non-negative
   localparam int Q_W     = 18;                  // dT*C6/2^23
   localparam int DEV_W   = Q_W + 1;             // TEMP + 1500
   localparam int OFF_W   = 35;                  // first-order offset
   localparam int SENS_W  = 34;                  // first-order sensitivity
   localparam int T2_W    = 17;
   localparam int TSUM_W  = 20;                  // temperature before saturation
   localparam int SQ_W    = 34;                  // squared deviations
   localparam int CORR_W  = 38;                  // OFF2 and SENS2
   localparam int ACC_W   = 40;                  // corrected OFF and SENS
   localparam int SPLIT_W = 20;                  // low part of SENS in the D1 product
   localparam int PL_W    = RAW_W + SPLIT_W;
   localparam int PH_W    = RAW_W + 1 + ACC_W - SPLIT_W;
   localparam int FULL_W  = 64;
   localparam int X_W     = FULL_W - 21;
   localparam int Y_W     = X_W + 1;
   localparam int PSUM_W  = Y_W - 15;

   // Shift amounts
   localparam int TEMP_SHIFT = 23;
   localparam int OFF_SHIFT  = 7;
   localparam int SENS_SHIFT = 8;
   localparam int T2_SHIFT   = 31;
   localparam int PRES_SHIFT = 21;
   localparam int OUT_SHIFT  = 15;

   // Temperature breakpoints and output ranges
   localparam int TEMP_REF  = 2000;
   localparam int TEMP_COLD = -1500;
   localparam int TEMP_MIN  = -4000;
   localparam int TEMP_MAX  = 8500;
   localparam int PRES_MIN  = 1000;
   localparam int PRES_MAX  = 120000;

   // Register stages from start to the result strobe
   localparam int PIPE_DEPTH = 9;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SENS     = 3'd0,
      CSR_OFF      = 3'd1,
      CSR_TCS      = 3'd2,
      CSR_TCO      = 3'd3,
      CSR_TREF     = 3'd4,
      CSR_TEMPSENS = 3'd5
   } bptc_csr_index_type;

   typedef struct packed {
      logic [COEFF_W-1:0] sens;
      logic [COEFF_W-1:0] off;
      logic [COEFF_W-1:0] tcs;
      logic [COEFF_W-1:0] tco;
      logic [COEFF_W-1:0] tref;
      logic [COEFF_W-1:0] tempsens;
   } bptc_coeff_type;

   // First-order terms of one item
   typedef struct packed {
      logic                     valid;
      logic [RAW_W-1:0]         d1;
      logic signed [Q_W-1:0]    q;
      logic signed [OFF_W-1:0]  off;
      logic signed [SENS_W-1:0] sens;
      logic [T2_W-1:0]          t2;
   } bptc_fo_type;

   // Corrected terms of one item
   typedef struct packed {
      logic                     valid;
      logic [RAW_W-1:0]         d1;
      logic signed [TEMP_W-1:0] temp;
      logic signed [ACC_W-1:0]  off;
      logic signed [ACC_W-1:0]  sens;
   } bptc_so_type;

endpackage

// ===== sv/baro_pressure_temp_compensation_core.sv =====
// An item passes through stages A to H and then the result register before its result strobe.
// Throughput: one item per cycle; nine register stages, each holding multiplies
// or wide adds, the widest being D1*SENS split into two partial products.
// busy stays low: the pipeline never stalls and results cannot be held off.
// Reset (synchronous, active high) clears all valid bits and the calibration words.
`timescale 1ns / 1ps
`include "baro_pressure_temp_compensation_core_defines.svh"

module baro_pressure_temp_compensation_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bptc_pkg::RAW_W-1:0]          req_raw_pressure,
   input  logic [bptc_pkg::RAW_W-1:0]          req_raw_temperature,
   output logic                                rsp_valid,
   output logic signed [bptc_pkg::TEMP_W-1:0]  rsp_temperature,
   output logic [bptc_pkg::PRES_W-1:0]         rsp_pressure,
   input  logic                                csr_write_en,
   input  logic [bptc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bptc_pkg::COEFF_W-1:0]        csr_wdata
);
   import bptc_pkg::*;

   bptc_coeff_type coeff;
   bptc_fo_type    fo;
   bptc_so_type    so;
   logic           item_take;

   // Every cycle can take an item
   assign busy      = 1'b0;
   assign item_take = start && !busy;

   bptc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .coeff        (coeff)
   );

   bptc_first_order u_first (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (item_take),
      .raw_pressure    (req_raw_pressure),
      .raw_temperature (req_raw_temperature),
      .coeff           (coeff),
      .fo              (fo)
   );

   bptc_second_order u_second (
      .clock (clock),
      .reset (reset),
      .fo    (fo),
      .so    (so)
   );

   bptc_pressure u_pressure (
      .clock           (clock),
      .reset           (reset),
      .so              (so),
      .rsp_valid       (rsp_valid),
      .rsp_temperature (rsp_temperature),
      .rsp_pressure    (rsp_pressure)
   );

   // Each result strobe answers an item taken a fixed number of cycles earlier
   `BPTC_ASSERT_IMP(a_rsp_latency, clock, reset, rsp_valid, $past(item_take, PIPE_DEPTH))

endmodule

// ===== sv/bptc_csr.sv =====
// Calibration word registers of the barometric compensation core.
// Depends on bptc_pkg.
`timescale 1ns / 1ps

module bptc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [bptc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bptc_pkg::COEFF_W-1:0]       csr_wdata,
   output bptc_pkg::bptc_coeff_type           coeff
);
   import bptc_pkg::*;

   bptc_coeff_type coeff_ff;
   bptc_coeff_type coeff_in;

   // Decode the write; indexes beyond the list are dropped
   always_comb begin
      coeff_in = coeff_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SENS:     coeff_in.sens     = csr_wdata;
            CSR_OFF:      coeff_in.off      = csr_wdata;
            CSR_TCS:      coeff_in.tcs      = csr_wdata;
            CSR_TCO:      coeff_in.tco      = csr_wdata;
            CSR_TREF:     coeff_in.tref     = csr_wdata;
            CSR_TEMPSENS: coeff_in.tempsens = csr_wdata;
            default:      coeff_in          = coeff_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else begin
         coeff_ff <= coeff_in;
      end
   end

   assign coeff = coeff_ff;

endmodule

// ===== sv/bptc_first_order.sv =====
// First-order section: dT, the four dT products and the first-order TEMP, OFF, SENS, T2.
// Three register stages. Depends on bptc_pkg.
`timescale 1ns / 1ps

module bptc_first_order (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [bptc_pkg::RAW_W-1:0]     raw_pressure,
   input  logic [bptc_pkg::RAW_W-1:0]     raw_temperature,
   input  bptc_pkg::bptc_coeff_type       coeff,
   output bptc_pkg::bptc_fo_type          fo
);
   import bptc_pkg::*;

   // Stage A: dT
   logic                     a_valid_ff;
   logic [RAW_W-1:0]         a_d1_ff;
   logic signed [DT_W-1:0]   a_dt_ff;
   logic signed [DT_W-1:0]   a_dt_in;

   // Stage B: products of dT
   logic                       b_valid_ff;
   logic [RAW_W-1:0]           b_d1_ff;
   logic signed [PROD_W-1:0]   b_ptemp_ff, b_ptemp_in;
   logic signed [PROD_W-1:0]   b_poff_ff, b_poff_in;
   logic signed [PROD_W-1:0]   b_psens_ff, b_psens_in;
   logic signed [2*DT_W-1:0]   b_dsq_full;
   logic [DSQ_W-1:0]           b_sq_ff, b_sq_in;

   // Stage C: first-order terms
   bptc_fo_type                fo_ff, fo_in;
   logic                       q_round;
   logic signed [Q_W:0]        q_full;

   // Subtract the reference temperature
   assign a_dt_in = $signed({1'b0, raw_temperature}) - $signed({1'b0, coeff.tref, 8'h00});

   // Multiply dT by the calibration words and by itself
   always_comb begin
      b_ptemp_in = a_dt_ff * $signed({1'b0, coeff.tempsens});
      b_poff_in  = a_dt_ff * $signed({1'b0, coeff.tco});
      b_psens_in = a_dt_ff * $signed({1'b0, coeff.tcs});
      b_dsq_full = a_dt_ff * a_dt_ff;
      b_sq_in    = b_dsq_full[DSQ_W-1:0];
   end

   // Scale the products; TEMP truncates toward zero, the rest floor
   always_comb begin
      q_round = b_ptemp_ff[PROD_W-1] & (|b_ptemp_ff[TEMP_SHIFT-1:0]);
      q_full  = $signed(b_ptemp_ff[PROD_W-1:TEMP_SHIFT]) + $signed({{Q_W{1'b0}}, q_round});
      fo_in.valid = b_valid_ff;
      fo_in.d1    = b_d1_ff;
      fo_in.q     = q_full[Q_W-1:0];
      fo_in.off   = $signed({3'b000, coeff.off, 16'h0000})
                  + $signed(b_poff_ff[PROD_W-1:OFF_SHIFT]);
      fo_in.sens  = $signed({3'b000, coeff.sens, 15'h0000})
                  + $signed(b_psens_ff[PROD_W-1:SENS_SHIFT]);
      fo_in.t2    = b_sq_ff[DSQ_W-1:T2_SHIFT];
   end

   // Advance the valid bits; load the stage C item whole
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         fo_ff.valid <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         fo_ff      <= fo_in;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      a_d1_ff    <= raw_pressure;
      a_dt_ff    <= a_dt_in;
      b_d1_ff    <= a_d1_ff;
      b_ptemp_ff <= b_ptemp_in;
      b_poff_ff  <= b_poff_in;
      b_psens_ff <= b_psens_in;
      b_sq_ff    <= b_sq_in;
   end

   assign fo = fo_ff;

endmodule

// ===== sv/bptc_second_order.sv =====
// Second-order section: low-temperature corrections of TEMP, OFF and SENS.
// Three register stages. Depends on bptc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "baro_pressure_temp_compensation_core_defines.svh"

module bptc_second_order (
   input  logic                     clock,
   input  logic                     reset,
   input  bptc_pkg::bptc_fo_type    fo,
   output bptc_pkg::bptc_so_type    so
);
   import bptc_pkg::*;

   // Stage D: squared deviations and uncorrected-to-corrected temperature
   logic                       d_valid_ff;
   logic                       d_lt20_ff, d_lt20_in;
   logic                       d_lt15_ff, d_lt15_in;
   logic [RAW_W-1:0]           d_d1_ff;
   logic signed [OFF_W-1:0]    d_off_ff;
   logic signed [SENS_W-1:0]   d_sens_ff;
   logic [SQ_W-1:0]            d_sq_ff, d_sq_in;
   logic [SQ_W-1:0]            d_sq2_ff, d_sq2_in;
   logic signed [TSUM_W-1:0]   d_temp_ff, d_temp_in;
   logic signed [DEV_W-1:0]    dev2;
   logic signed [2*Q_W-1:0]    sq_full;
   logic signed [2*DEV_W-1:0]  sq2_full;
   logic [T2_W-1:0]            t2_sel;

   // Stage E: OFF2, SENS2 and saturated temperature
   logic                       e_valid_ff;
   logic [RAW_W-1:0]           e_d1_ff;
   logic signed [OFF_W-1:0]    e_off_ff;
   logic signed [SENS_W-1:0]   e_sens_ff;
   logic [CORR_W-1:0]          e_off2_ff, e_off2_in;
   logic [CORR_W-1:0]          e_sens2_ff, e_sens2_in;
   logic signed [TEMP_W-1:0]   e_temp_ff, e_temp_in;
   logic [SQ_W+2:0]            five_sq;
   logic [SQ_W+2:0]            seven_sq2;
   logic [SQ_W+3:0]            eleven_sq2;

   // Stage F: corrected OFF and SENS
   bptc_so_type                so_ff, so_in;

   // Square the deviations from 20 degC and from -15 degC
   always_comb begin
      dev2      = DEV_W'(fo.q) + DEV_W'(TEMP_REF - TEMP_COLD);
      sq_full   = fo.q * fo.q;
      sq2_full  = dev2 * dev2;
      d_sq_in   = sq_full[SQ_W-1:0];
      d_sq2_in  = sq2_full[SQ_W-1:0];
      d_lt20_in = fo.q[Q_W-1];
      d_lt15_in = fo.q < (TEMP_COLD - TEMP_REF);
      t2_sel    = d_lt20_in ? fo.t2 : '0;
      d_temp_in = TSUM_W'(fo.q) + TSUM_W'(TEMP_REF)
                - $signed({{(TSUM_W-T2_W){1'b0}}, t2_sel});
   end

   // Build the correction terms by shift and add
   always_comb begin
      five_sq    = {1'b0, d_sq_ff, 2'b00} + {3'b000, d_sq_ff};
      seven_sq2  = {d_sq2_ff, 3'b000} - {3'b000, d_sq2_ff};
      eleven_sq2 = {1'b0, d_sq2_ff, 3'b000} + {3'b000, d_sq2_ff, 1'b0} + {4'b0000, d_sq2_ff};
      e_off2_in  = '0;
      e_sens2_in = '0;
      if (d_lt20_ff) begin
         e_off2_in  = {2'b00, five_sq[SQ_W+2:1]} + (d_lt15_ff ? {1'b0, seven_sq2} : '0);
         e_sens2_in = {3'b000, five_sq[SQ_W+2:2]}
                    + (d_lt15_ff ? {1'b0, eleven_sq2[SQ_W+3:1]} : '0);
      end
   end

   // Saturate the temperature
   always_comb begin
      if (d_temp_ff < TEMP_MIN) begin
         e_temp_in = TEMP_W'(TEMP_MIN);
      end else if (d_temp_ff > TEMP_MAX) begin
         e_temp_in = TEMP_W'(TEMP_MAX);
      end else begin
         e_temp_in = d_temp_ff[TEMP_W-1:0];
      end
   end

   // Take the corrections off the first-order terms
   always_comb begin
      so_in.valid = e_valid_ff;
      so_in.d1    = e_d1_ff;
      so_in.temp  = e_temp_ff;
      so_in.off   = ACC_W'(e_off_ff) - $signed({2'b00, e_off2_ff});
      so_in.sens  = ACC_W'(e_sens_ff) - $signed({2'b00, e_sens2_ff});
   end

   // Advance the valid bits; load the stage F item whole
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff  <= 1'b0;
         e_valid_ff  <= 1'b0;
         so_ff.valid <= 1'b0;
      end else begin
         d_valid_ff <= fo.valid;
         e_valid_ff <= d_valid_ff;
         so_ff      <= so_in;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      d_lt20_ff  <= d_lt20_in;
      d_lt15_ff  <= d_lt15_in;
      d_d1_ff    <= fo.d1;
      d_off_ff   <= fo.off;
      d_sens_ff  <= fo.sens;
      d_sq_ff    <= d_sq_in;
      d_sq2_ff   <= d_sq2_in;
      d_temp_ff  <= d_temp_in;
      e_d1_ff    <= d_d1_ff;
      e_off_ff   <= d_off_ff;
      e_sens_ff  <= d_sens_ff;
      e_off2_ff  <= e_off2_in;
      e_sens2_ff <= e_sens2_in;
      e_temp_ff  <= e_temp_in;
   end

   assign so = so_ff;

   // Below -15 degC is always below 20 degC
   `BPTC_ASSERT_IMP(a_cold_is_cool, clock, reset, d_valid_ff && d_lt15_ff, d_lt20_ff)
   // No correction at or above 20 degC
   `BPTC_ASSERT_NXT(a_warm_no_corr, clock, reset, d_valid_ff && !d_lt20_ff, e_off2_ff == '0)

endmodule

// ===== sv/bptc_pressure.sv =====
// Pressure section: D1 times SENS in two partial products, offset, scaling,
// saturation and the result register. Depends on bptc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "baro_pressure_temp_compensation_core_defines.svh"

module bptc_pressure (
   input  logic                               clock,
   input  logic                               reset,
   input  bptc_pkg::bptc_so_type              so,
   output logic                               rsp_valid,
   output logic signed [bptc_pkg::TEMP_W-1:0] rsp_temperature,
   output logic [bptc_pkg::PRES_W-1:0]        rsp_pressure
);
   import bptc_pkg::*;

   // Stage G: partial products
   logic                       g_valid_ff;
   logic signed [TEMP_W-1:0]   g_temp_ff;
   logic signed [ACC_W-1:0]    g_off_ff;
   logic [PL_W-1:0]            g_pl_ff, g_pl_in;
   logic signed [PH_W-1:0]     g_ph_ff, g_ph_in;

   // Stage H: D1*SENS/2^21
   logic                       h_valid_ff;
   logic signed [TEMP_W-1:0]   h_temp_ff;
   logic signed [ACC_W-1:0]    h_off_ff;
   logic signed [X_W-1:0]      h_x_ff, h_x_in;
   logic signed [FULL_W-1:0]   prod;

   // Result register
   logic                       rsp_valid_ff;
   logic signed [TEMP_W-1:0]   rsp_temperature_ff;
   logic [PRES_W-1:0]          rsp_pressure_ff, rsp_pressure_in;
   logic signed [Y_W-1:0]      y_full;
   logic signed [PSUM_W-1:0]   pres;

   // Split SENS into an unsigned low part and a signed high part
   always_comb begin
      g_pl_in = so.d1 * so.sens[SPLIT_W-1:0];
      g_ph_in = $signed({1'b0, so.d1}) * $signed(so.sens[ACC_W-1:SPLIT_W]);
   end

   // Recombine and scale
   always_comb begin
      prod   = (FULL_W'(g_ph_ff) <<< SPLIT_W) + $signed({{(FULL_W-PL_W){1'b0}}, g_pl_ff});
      h_x_in = $signed(prod[FULL_W-1:PRES_SHIFT]);
   end

   // Remove the offset, scale and saturate
   always_comb begin
      y_full = Y_W'(h_x_ff) - Y_W'(h_off_ff);
      pres   = $signed(y_full[Y_W-1:OUT_SHIFT]);
      if (pres < PRES_MIN) begin
         rsp_pressure_in = PRES_W'(PRES_MIN);
      end else if (pres > PRES_MAX) begin
         rsp_pressure_in = PRES_W'(PRES_MAX);
      end else begin
         rsp_pressure_in = pres[PRES_W-1:0];
      end
   end

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff   <= 1'b0;
         h_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         g_valid_ff   <= so.valid;
         h_valid_ff   <= g_valid_ff;
         rsp_valid_ff <= h_valid_ff;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      g_temp_ff          <= so.temp;
      g_off_ff           <= so.off;
      g_pl_ff            <= g_pl_in;
      g_ph_ff            <= g_ph_in;
      h_temp_ff          <= g_temp_ff;
      h_off_ff           <= g_off_ff;
      h_x_ff             <= h_x_in;
      rsp_temperature_ff <= h_temp_ff;
      rsp_pressure_ff    <= rsp_pressure_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = rsp_temperature_ff;
   assign rsp_pressure    = rsp_pressure_ff;

   // Saturation keeps both results inside the sensor ranges
   `BPTC_ASSERT_IMP(a_pres_range, clock, reset, rsp_valid_ff, (rsp_pressure_ff >= PRES_MIN) && (rsp_pressure_ff <= PRES_MAX))
   `BPTC_ASSERT_IMP(a_temp_range, clock, reset, rsp_valid_ff, (rsp_temperature_ff >= TEMP_MIN) && (rsp_temperature_ff <= TEMP_MAX))

endmodule
